// File: sv/fcpd_pkg.sv
// Shared types and constants for the fragmented channel packet deframer.
package fcpd_pkg;

  localparam int FLAG_FIRST_BIT = 0;
  localparam int FLAG_LAST_BIT = 1;
  localparam int FLAG_CONTROL_BIT = 2;
  localparam int FLAG_ENCRYPTED_BIT = 3;

  localparam logic [1:0] PH_HEADER = 2'd0;
  localparam logic [1:0] PH_TOTAL = 2'd1;
  localparam logic [1:0] PH_PAYLOAD = 2'd2;

  localparam logic [1:0] ERR_NONE = 2'd0;
  localparam logic [1:0] ERR_FIRST_ACTIVE = 2'd1;
  localparam logic [1:0] ERR_CHANNEL = 2'd2;

  localparam logic [2:0] HIDX_CHANNEL = 3'd0;
  localparam logic [2:0] HIDX_FLAGS = 3'd1;
  localparam logic [2:0] HIDX_LEN_HI = 3'd2;
  localparam logic [2:0] TOTAL_BYTES = 3'd4;

  localparam int QDEPTH = 4;
  localparam int QAW = $clog2(QDEPTH);
  localparam int QCW = $clog2(QDEPTH + 1);

  typedef struct packed {
    logic [7:0]  out_byte;
    logic        byte_valid;
    logic [7:0]  channel;
    logic        encrypted;
    logic        control;
    logic        message_last;
    logic [31:0] total_length;
    logic [1:0]  error_code;
  } result_t;

endpackage

// File: sv/fragmented_channel_packet_deframer_core.sv
// Top level of the fragmented channel packet deframer.
// Each result word is written into the result queue and then loaded into the output register before it appears.
// Throughput: one byte per cycle while the result queue is not full; the header parser updates its state per byte.
// A four-word result queue and an output register let input and output stall independently.
// Reset is synchronous, active low; it returns the parser to the header phase and empties
// the queue and the output register.
module fragmented_channel_packet_deframer_core import fcpd_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_out_byte,
  output logic        out_byte_valid,
  output logic [7:0]  out_channel,
  output logic        out_encrypted,
  output logic        out_control,
  output logic        out_message_last,
  output logic [31:0] out_total_length,
  output logic [1:0]  out_error_code
);

  logic    take;
  logic    push;
  result_t push_data;
  logic    full;
  logic    pop;
  logic    q_valid;
  result_t q_data;
  result_t out_data;

  assign in_ready = !full;
  assign take = in_valid && in_ready;

  fcpd_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .take      (take),
    .data_byte (in_data_byte),
    .push      (push),
    .push_data (push_data)
  );

  fcpd_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .full      (full),
    .pop       (pop),
    .q_valid   (q_valid),
    .q_data    (q_data)
  );

  fcpd_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_data    (q_data),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  assign out_out_byte = out_data.out_byte;
  assign out_byte_valid = out_data.byte_valid;
  assign out_channel = out_data.channel;
  assign out_encrypted = out_data.encrypted;
  assign out_control = out_data.control;
  assign out_message_last = out_data.message_last;
  assign out_total_length = out_data.total_length;
  assign out_error_code = out_data.error_code;

endmodule

// File: sv/fcpd_front.sv
// Front end: parses the framed byte stream and produces at most one result word per byte.
module fcpd_front import fcpd_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       take,
  input  logic [7:0] data_byte,
  output logic       push,
  output result_t    push_data
);

  logic [1:0]  phase_r, phase_nxt;
  logic [2:0]  hidx_r, hidx_nxt;
  logic [7:0]  fch_r, fch_nxt;
  logic [3:0]  fflags_r, fflags_nxt;
  logic [15:0] flen_r, flen_nxt;
  logic [15:0] prem_r, prem_nxt;
  logic [31:0] dtotal_r, dtotal_nxt;
  logic        ract_r, ract_nxt;
  logic [7:0]  mch_r, mch_nxt;
  logic        menc_r, menc_nxt;
  logic        mctl_r, mctl_nxt;
  logic        disc_r, disc_nxt;

  always_comb begin
    logic        do_eoh;
    logic [15:0] eh_len;
    logic [15:0] rem_dec;
    logic        first;
    logic        last;
    logic        ends;

    phase_nxt = phase_r;
    hidx_nxt = hidx_r;
    fch_nxt = fch_r;
    fflags_nxt = fflags_r;
    flen_nxt = flen_r;
    prem_nxt = prem_r;
    dtotal_nxt = dtotal_r;
    ract_nxt = ract_r;
    mch_nxt = mch_r;
    menc_nxt = menc_r;
    mctl_nxt = mctl_r;
    disc_nxt = disc_r;
    push = 1'b0;
    push_data = '0;
    do_eoh = 1'b0;
    eh_len = flen_r;
    first = fflags_r[FLAG_FIRST_BIT];
    last = fflags_r[FLAG_LAST_BIT];
    rem_dec = prem_r - 16'd1;
    ends = 1'b0;

    if (phase_r == PH_PAYLOAD) begin
      prem_nxt = rem_dec;
      ends = (rem_dec == 16'd0) && last;
      if (rem_dec == 16'd0) begin
        phase_nxt = PH_HEADER;
        hidx_nxt = '0;
      end
      if (!disc_r) begin
        if (ends) begin
          ract_nxt = 1'b0;
        end
        push = 1'b1;
        push_data.out_byte = data_byte;
        push_data.byte_valid = 1'b1;
        push_data.channel = mch_r;
        push_data.encrypted = menc_r;
        push_data.control = mctl_r;
        push_data.message_last = ends;
        push_data.total_length = dtotal_r;
        push_data.error_code = ERR_NONE;
      end
    end else if (phase_r == PH_TOTAL) begin
      dtotal_nxt = {dtotal_r[23:0], data_byte};
      hidx_nxt = hidx_r + 3'd1;
      if (hidx_nxt >= TOTAL_BYTES) begin
        do_eoh = 1'b1;
        eh_len = flen_r;
      end
    end else begin
      phase_nxt = PH_HEADER;
      unique case (hidx_r)
        HIDX_CHANNEL: begin
          fch_nxt = data_byte;
          hidx_nxt = hidx_r + 3'd1;
        end
        HIDX_FLAGS: begin
          fflags_nxt = data_byte[3:0];
          hidx_nxt = hidx_r + 3'd1;
        end
        HIDX_LEN_HI: begin
          flen_nxt = {data_byte, 8'h00};
          hidx_nxt = hidx_r + 3'd1;
        end
        default: begin
          flen_nxt = flen_r + {8'h00, data_byte};
          if (first && !last) begin
            phase_nxt = PH_TOTAL;
            hidx_nxt = '0;
            dtotal_nxt = '0;
          end else begin
            do_eoh = 1'b1;
            eh_len = flen_nxt;
          end
        end
      endcase
    end

    if (do_eoh) begin
      disc_nxt = 1'b0;
      if (first && !last) begin
        if (ract_r) begin
          ract_nxt = 1'b0;
          disc_nxt = 1'b1;
          push = 1'b1;
          push_data = '0;
          push_data.channel = fch_r;
          push_data.error_code = ERR_FIRST_ACTIVE;
        end else begin
          ract_nxt = 1'b1;
          mch_nxt = fch_r;
          menc_nxt = fflags_r[FLAG_ENCRYPTED_BIT];
          mctl_nxt = fflags_r[FLAG_CONTROL_BIT];
        end
      end else if (ract_r) begin
        if (fch_r != mch_r) begin
          ract_nxt = 1'b0;
          disc_nxt = 1'b1;
          push = 1'b1;
          push_data = '0;
          push_data.channel = fch_r;
          push_data.error_code = ERR_CHANNEL;
        end
      end else if (last) begin
        mch_nxt = fch_r;
        menc_nxt = fflags_r[FLAG_ENCRYPTED_BIT];
        mctl_nxt = fflags_r[FLAG_CONTROL_BIT];
        dtotal_nxt = {16'h0000, eh_len};
      end else begin
        disc_nxt = 1'b1;
      end

      prem_nxt = eh_len;
      hidx_nxt = '0;
      if (eh_len == 16'd0) begin
        phase_nxt = PH_HEADER;
        if (!disc_nxt && last) begin
          ract_nxt = 1'b0;
          push = 1'b1;
          push_data = '0;
          push_data.channel = mch_nxt;
          push_data.encrypted = menc_nxt;
          push_data.control = mctl_nxt;
          push_data.message_last = 1'b1;
          push_data.total_length = dtotal_nxt;
          push_data.error_code = ERR_NONE;
        end
      end else begin
        phase_nxt = PH_PAYLOAD;
      end
    end

    push = push && take;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HEADER;
      hidx_r <= '0;
      fch_r <= '0;
      fflags_r <= '0;
      flen_r <= '0;
      prem_r <= '0;
      dtotal_r <= '0;
      ract_r <= 1'b0;
      mch_r <= '0;
      menc_r <= 1'b0;
      mctl_r <= 1'b0;
      disc_r <= 1'b0;
    end else if (take) begin
      phase_r <= phase_nxt;
      hidx_r <= hidx_nxt;
      fch_r <= fch_nxt;
      fflags_r <= fflags_nxt;
      flen_r <= flen_nxt;
      prem_r <= prem_nxt;
      dtotal_r <= dtotal_nxt;
      ract_r <= ract_nxt;
      mch_r <= mch_nxt;
      menc_r <= menc_nxt;
      mctl_r <= mctl_nxt;
      disc_r <= disc_nxt;
    end
  end

  // In the payload phase the header position is always cleared.
  a_payload_hidx: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_PAYLOAD) |-> (hidx_r == '0))
    else $error("header index not cleared in payload phase");

  // An error word never carries payload or an end-of-message mark.
  a_err_shape: assert property (@(posedge clk) disable iff (!rst_n)
    (push && push_data.error_code != ERR_NONE) |->
      (!push_data.byte_valid && !push_data.message_last))
    else $error("error word carries payload or last mark");

  // A payload byte is only produced from the payload phase.
  a_byte_phase: assert property (@(posedge clk) disable iff (!rst_n)
    (push && push_data.byte_valid) |-> (phase_r == PH_PAYLOAD))
    else $error("payload byte outside payload phase");

endmodule

// File: sv/fcpd_queue.sv
// Short result queue between the parsing front end and the output stage.
module fcpd_queue import fcpd_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  result_t push_data,
  output logic    full,
  input  logic    pop,
  output logic    q_valid,
  output result_t q_data
);

  result_t           mem_r [QDEPTH];
  logic [QAW-1:0]    wptr_r, rptr_r;
  logic [QCW-1:0]    cnt_r, cnt_nxt;

  assign full = (cnt_r == QCW'(QDEPTH));
  assign q_valid = (cnt_r != '0);
  assign q_data = mem_r[rptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + QCW'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - QCW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wptr_r <= wptr_r + QAW'(1);
      end
      if (pop) begin
        rptr_r <= rptr_r + QAW'(1);
      end
      cnt_r <= cnt_nxt;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && full))
    else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(pop && !q_valid))
    else $error("pop from empty queue");

  a_count_up: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> (cnt_r == $past(cnt_r) + QCW'(1)))
    else $error("queue count did not advance on push");

endmodule

// File: sv/fcpd_back.sv
// Back end: output register that hands queued result words to the consumer.
module fcpd_back import fcpd_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    q_valid,
  input  result_t q_data,
  output logic    pop,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t out_data
);

  logic    ovalid_r;
  result_t odata_r;

  assign pop = q_valid && (!ovalid_r || out_ready);
  assign out_valid = ovalid_r;
  assign out_data = odata_r;

  always_ff @(posedge clk) begin
    if (pop) begin
      odata_r <= q_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ovalid_r <= 1'b0;
    end else if (pop) begin
      ovalid_r <= 1'b1;
    end else if (out_ready) begin
      ovalid_r <= 1'b0;
    end
  end

  // A word that is not taken is neither replaced nor dropped.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (ovalid_r && !out_ready) |=> (ovalid_r && odata_r == $past(odata_r)))
    else $error("output word changed while stalled");

  // A waiting queue word reaches the output register when it is free.
  a_refill: assert property (@(posedge clk) disable iff (!rst_n)
    (q_valid && !ovalid_r) |=> ovalid_r)
    else $error("output register not refilled");

  a_empty_pop: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> q_valid)
    else $error("pop without queued word");

endmodule
